FILE: sv/e2cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_pkg
// shared types, constants and table functions for the epoch to calendar block
// ----------------------------------------------------------------------------
package e2cal_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int SECS_W      = 33;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [32:0] LAST_SECOND = 33'd4102444799;

    localparam int SEC_PER_MIN   = 60;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_DAY   = 86400;
    localparam int DAYS_PER_WEEK = 7;
    localparam int DAYS_PER_CYC  = 4 * 365 + 1;
    localparam int YEAR1_START   = 365;
    localparam int YEAR2_START   = 365 * 2;
    localparam int YEAR3_START   = 365 * 3 + 1;
    localparam int EPOCH_YEAR    = 70;
    localparam int EPOCH_WDAY    = 4;

    // reciprocal shifts, chosen no narrower than the dividend so that the
    // estimate is low by at most one
    localparam int DAY_SHIFT   = 25;
    localparam int HOUR_SHIFT  = 17;
    localparam int CYC_SHIFT   = 16;
    localparam int WEEK_SHIFT  = 17;
    localparam int MIN_SHIFT   = 12;
    localparam int DAY_DIV     = SEC_PER_DAY / 128;
    localparam int RECIP_DAY   = (1 << DAY_SHIFT) / DAY_DIV;
    localparam int RECIP_HOUR  = (1 << HOUR_SHIFT) / SEC_PER_HOUR;
    localparam int RECIP_CYC   = (1 << CYC_SHIFT) / DAYS_PER_CYC;
    localparam int RECIP_WEEK  = (1 << WEEK_SHIFT) / DAYS_PER_WEEK;
    localparam int RECIP_MIN   = (1 << MIN_SHIFT) / SEC_PER_MIN;

    typedef struct packed {
        logic        oor;
        logic [31:0] secs;
    } t_item;

    // cumulative days before each month
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
        logic [8:0] v;
        case (mon)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = leap ? 9'd60  : 9'd59;
            4'd3:    v = leap ? 9'd91  : 9'd90;
            4'd4:    v = leap ? 9'd121 : 9'd120;
            4'd5:    v = leap ? 9'd152 : 9'd151;
            4'd6:    v = leap ? 9'd182 : 9'd181;
            4'd7:    v = leap ? 9'd213 : 9'd212;
            4'd8:    v = leap ? 9'd244 : 9'd243;
            4'd9:    v = leap ? 9'd274 : 9'd273;
            4'd10:   v = leap ? 9'd305 : 9'd304;
            4'd11:   v = leap ? 9'd335 : 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] month_of(input logic leap, input logic [8:0] yday);
        logic [3:0] m;
        m = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (month_start(leap, 4'(i)) <= yday) begin
                m = 4'(i);
            end
        end
        return m;
    endfunction

endpackage

FILE: sv/e2cal_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2cal_front
// input register; flags timestamps past the end of 2099
// ----------------------------------------------------------------------------
module e2cal_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [32:0]           i_secs,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output e2cal_pkg::t_item           o_item
);

    logic             r_vld;
    e2cal_pkg::t_item r_item;
    e2cal_pkg::t_item n_item;

    assign o_s_tready = !r_vld || i_ready;
    assign o_valid    = r_vld;
    assign o_item     = r_item;

    always_comb begin
        n_item.oor  = i_secs > e2cal_pkg::LAST_SECOND;
        n_item.secs = i_secs[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

FILE: sv/e2cal_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2cal_queue
// short register queue between the front and the conversion pipeline
// ----------------------------------------------------------------------------
module e2cal_queue #(
    parameter int DEPTH = e2cal_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire e2cal_pkg::t_item  i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output e2cal_pkg::t_item       o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    e2cal_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: sv/e2cal_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2cal_back
// seven-stage conversion pipeline: constant divisions by reciprocal multiply
// with a one-step correction, then year and month lookup
// ----------------------------------------------------------------------------
module e2cal_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire e2cal_pkg::t_item      i_item,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [47:0]                o_m_tdata,
    output logic                       o_m_tuser
);

    localparam int NUM_STAGES = 7;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] r_oor;
    logic [NUM_STAGES:0]   adv;

    // a stage moves when it is empty or the next one moves
    always_comb begin
        adv[NUM_STAGES] = i_m_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    assign o_ready    = adv[0];
    assign o_m_tvalid = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_oor[0] <= i_item.oor;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                r_oor[i] <= r_oor[i-1];
            end
        end
    end

    // stage 1: day estimate, t / 86400 = (t >> 7) / 675
    logic [40:0] n1_prod;
    logic [31:0] r1_secs;
    logic [15:0] r1_q;

    assign n1_prod = 41'(i_item.secs[31:7]) * 41'(e2cal_pkg::RECIP_DAY);

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_secs <= i_item.secs;
            r1_q    <= n1_prod[40:25];
        end
    end

    // stage 2: seconds left over, below two days
    logic [33:0] n2_rem;
    logic [17:0] r2_sod;
    logic [15:0] r2_q;

    assign n2_rem = 34'(r1_secs) - 34'(r1_q) * 34'(e2cal_pkg::SEC_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_sod <= n2_rem[17:0];
            r2_q   <= r1_q;
        end
    end

    // stage 3: correct the day count
    logic        n3_fix;
    logic [15:0] r3_days;
    logic [16:0] r3_sod;

    assign n3_fix = r2_sod >= 18'(e2cal_pkg::SEC_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_days <= n3_fix ? r2_q + 16'd1 : r2_q;
            r3_sod  <= n3_fix ? 17'(r2_sod - 18'(e2cal_pkg::SEC_PER_DAY)) : r2_sod[16:0];
        end
    end

    // stage 4: estimates for hour, four-year cycle and weekday
    logic [22:0] n4_hprod;
    logic [21:0] n4_cprod;
    logic [16:0] n4_w;
    logic [31:0] n4_wprod;
    logic [5:0]  r4_hest;
    logic [5:0]  r4_cest;
    logic [14:0] r4_west;
    logic [16:0] r4_sod;
    logic [15:0] r4_days;
    logic [16:0] r4_w;

    assign n4_hprod = 23'(r3_sod) * 23'(e2cal_pkg::RECIP_HOUR);
    assign n4_cprod = 22'(r3_days) * 22'(e2cal_pkg::RECIP_CYC);
    assign n4_w     = 17'(r3_days) + 17'(e2cal_pkg::EPOCH_WDAY);
    assign n4_wprod = 32'(n4_w) * 32'(e2cal_pkg::RECIP_WEEK);

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_hest <= n4_hprod[22:17];
            r4_cest <= n4_cprod[21:16];
            r4_west <= n4_wprod[31:17];
            r4_sod  <= r3_sod;
            r4_days <= r3_days;
            r4_w    <= n4_w;
        end
    end

    // stage 5: remainders with a one-step correction
    logic [16:0] n5_hrem;
    logic [15:0] n5_crem;
    logic [16:0] n5_wrem;
    logic        n5_hfix;
    logic        n5_cfix;
    logic        n5_wfix;
    logic [4:0]  r5_hour;
    logic [11:0] r5_soh;
    logic [5:0]  r5_cyc;
    logic [10:0] r5_cday;
    logic [2:0]  r5_wday;

    assign n5_hrem = r4_sod - 17'(17'(r4_hest) * 17'(e2cal_pkg::SEC_PER_HOUR));
    assign n5_crem = r4_days - 16'(16'(r4_cest) * 16'(e2cal_pkg::DAYS_PER_CYC));
    assign n5_wrem = r4_w - 17'(17'(r4_west) * 17'(e2cal_pkg::DAYS_PER_WEEK));
    assign n5_hfix = n5_hrem >= 17'(e2cal_pkg::SEC_PER_HOUR);
    assign n5_cfix = n5_crem >= 16'(e2cal_pkg::DAYS_PER_CYC);
    assign n5_wfix = n5_wrem >= 17'(e2cal_pkg::DAYS_PER_WEEK);

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r5_hour <= 5'(n5_hfix ? r4_hest + 6'd1 : r4_hest);
            r5_soh  <= 12'(n5_hfix ? n5_hrem - 17'(e2cal_pkg::SEC_PER_HOUR) : n5_hrem);
            r5_cyc  <= n5_cfix ? r4_cest + 6'd1 : r4_cest;
            r5_cday <= 11'(n5_cfix ? n5_crem - 16'(e2cal_pkg::DAYS_PER_CYC) : n5_crem);
            r5_wday <= 3'(n5_wfix ? n5_wrem - 17'(e2cal_pkg::DAYS_PER_WEEK) : n5_wrem);
        end
    end

    // stage 6: minute estimate, year within the cycle
    logic [18:0] n6_mprod;
    logic [1:0]  n6_yoff;
    logic [10:0] n6_ystart;
    logic        n6_leap;
    logic [6:0]  r6_mest;
    logic [11:0] r6_soh;
    logic [4:0]  r6_hour;
    logic [2:0]  r6_wday;
    logic [7:0]  r6_year;
    logic [8:0]  r6_yday;
    logic        r6_leap;

    assign n6_mprod = 19'(r5_soh) * 19'(e2cal_pkg::RECIP_MIN);

    always_comb begin
        n6_yoff   = 2'd0;
        n6_ystart = 11'd0;
        n6_leap   = 1'b0;
        if (r5_cday >= 11'(e2cal_pkg::YEAR3_START)) begin
            n6_yoff   = 2'd3;
            n6_ystart = 11'(e2cal_pkg::YEAR3_START);
        end else if (r5_cday >= 11'(e2cal_pkg::YEAR2_START)) begin
            n6_yoff   = 2'd2;
            n6_ystart = 11'(e2cal_pkg::YEAR2_START);
            n6_leap   = 1'b1;
        end else if (r5_cday >= 11'(e2cal_pkg::YEAR1_START)) begin
            n6_yoff   = 2'd1;
            n6_ystart = 11'(e2cal_pkg::YEAR1_START);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r6_mest <= n6_mprod[18:12];
            r6_soh  <= r5_soh;
            r6_hour <= r5_hour;
            r6_wday <= r5_wday;
            r6_year <= 8'({r5_cyc, n6_yoff}) + 8'(e2cal_pkg::EPOCH_YEAR);
            r6_yday <= 9'(r5_cday - n6_ystart);
            r6_leap <= n6_leap;
        end
    end

    // stage 7: minute and second, month lookup, output register
    logic [11:0] n7_mrem;
    logic        n7_mfix;
    logic [3:0]  n7_mon;
    logic [8:0]  n7_mday;
    logic [5:0]  r7_sec;
    logic [5:0]  r7_min;
    logic [4:0]  r7_hour;
    logic [2:0]  r7_wday;
    logic [7:0]  r7_year;
    logic [8:0]  r7_yday;
    logic [3:0]  r7_mon;
    logic [4:0]  r7_mday;

    assign n7_mrem = r6_soh - 12'(12'(r6_mest) * 12'(e2cal_pkg::SEC_PER_MIN));
    assign n7_mfix = n7_mrem >= 12'(e2cal_pkg::SEC_PER_MIN);
    assign n7_mon  = e2cal_pkg::month_of(r6_leap, r6_yday);
    assign n7_mday = r6_yday + 9'd1 - e2cal_pkg::month_start(r6_leap, n7_mon);

    // past the end of 2099 every field but the flag reads zero
    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            if (r_oor[5]) begin
                r7_sec  <= '0;
                r7_min  <= '0;
                r7_hour <= '0;
                r7_wday <= '0;
                r7_year <= '0;
                r7_yday <= '0;
                r7_mon  <= '0;
                r7_mday <= '0;
            end else begin
                r7_sec  <= 6'(n7_mfix ? n7_mrem - 12'(e2cal_pkg::SEC_PER_MIN) : n7_mrem);
                r7_min  <= 6'(n7_mfix ? r6_mest + 7'd1 : r6_mest);
                r7_hour <= r6_hour;
                r7_wday <= r6_wday;
                r7_year <= r6_year;
                r7_yday <= r6_yday;
                r7_mon  <= n7_mon;
                r7_mday <= n7_mday[4:0];
            end
        end
    end

    assign o_m_tdata = {2'b00, r7_mday, r7_mon, r7_yday, r7_year,
                        r7_wday, r7_hour, r7_min, r7_sec};
    assign o_m_tuser = r_oor[NUM_STAGES-1];

endmodule
`default_nettype wire

FILE: sv/epoch_to_calendar.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_calendar
// unix epoch seconds to utc calendar date and time of day
//
// channel  dir  payload                                    marker
// s        in   epoch_seconds                              -
// m        out  sec, min, hour, wday, year, yday, mon, mday out_of_range on tuser
//
// one word per cycle sustained while i_m_tready stays high; a word passes
// the input register, then the queue, then the conversion pipeline,
// whose depth is set by the chain of reciprocal multiplies
// while a finished word waits on i_m_tready, empty pipeline stages keep
// filling; back pressure fills the pipeline and then the queue
// reset clears only the valid flags, queue pointers and queue count
// ----------------------------------------------------------------------------
module epoch_to_calendar #(
    parameter int QUEUE_DEPTH = e2cal_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // epoch_seconds[32:0], zero pad
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // second, minute, hour, weekday,
                                          // years_since_1900, day_of_year,
                                          // month_index, day_of_month, zero pad
    output logic             o_m_tuser    // out_of_range
);

    logic             front_valid;
    logic             front_ready;
    e2cal_pkg::t_item front_item;
    logic             queue_valid;
    logic             queue_ready;
    e2cal_pkg::t_item queue_item;
    logic             unused_pad;

    assign unused_pad = |i_s_tdata[39:33];

    e2cal_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_secs     (i_s_tdata[32:0]),
        .o_valid    (front_valid),
        .i_ready    (front_ready),
        .o_item     (front_item)
    );

    e2cal_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    e2cal_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .o_ready    (queue_ready),
        .i_item     (queue_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for epoch_to_calendar
// drives epoch seconds on the input stream with random gaps, checks every
// output word field by field against an in-house calendar predictor, and
// holds the output off once for a long stretch so the block backs up
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 30;

    // one output word with tuser on top
    typedef struct packed {
        logic       oor;
        logic [1:0] pad;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [8:0] yday;
        logic [7:0] year;
        logic [2:0] wday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_date_word;

    typedef struct {
        logic [39:0] word;
        bit          typed;
        logic        oor;
        int          sec, mnt, hr, wd, yr, yd, mo, md;
    } t_stim_row;

    localparam int DAYS_BEFORE_MONTH [2][12] = '{
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}
    };

    localparam int NUM_DIRECTED = 19;

    // typed rows are read straight off the calendar, the rest go through the predictor
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{40'd0,            1'b1, 1'b0, 0,  0,  0,  4, 70,  0,   0,  1},
        '{40'd59,           1'b1, 1'b0, 59, 0,  0,  4, 70,  0,   0,  1},
        '{40'd86399,        1'b1, 1'b0, 59, 59, 23, 4, 70,  0,   0,  1},
        '{40'd4102444799,   1'b1, 1'b0, 59, 59, 23, 4, 199, 364, 11, 31},
        '{40'd4102444800,   1'b1, 1'b1, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd4294967296,   1'b1, 1'b1, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'h01_FFFF_FFFF, 1'b1, 1'b1, 0,  0,  0,  0, 0,   0,   0,  0},
        // junk above bit 32 must be ignored
        '{40'hFE_0000_0000, 1'b1, 1'b0, 0,  0,  0,  4, 70,  0,   0,  1},
        '{40'hAB_0000_0000, 1'b1, 1'b1, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd31535999,     1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd63071999,     1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd68212800,     1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd94694399,     1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd94694400,     1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd951782400,    1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd2147483647,   1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd2147483648,   1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'd4007836799,   1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0},
        '{40'hFF_F484_1E7F, 1'b0, 1'b0, 0,  0,  0,  0, 0,   0,   0,  0}
    };

    // day offsets within a four-year cycle around year and month edges
    localparam int NUM_EDGES = 19;
    localparam int CYCLE_EDGES [NUM_EDGES] = '{
        0, 31, 59, 60, 90, 91, 181, 334, 335, 364, 365, 729, 730, 789, 790,
        1094, 1095, 1096, 1460
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // epoch_seconds[32:0], zero pad
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // second, minute, hour, weekday, years_since_1900,
                                    // day_of_year, month_index, day_of_month, zero pad
    logic        o_m_tuser;         // out_of_range

    t_date_word pending_dates [$];
    int         mismatches    = 0;
    int         idle_cycles   = 0;
    bit         send_calm     = 1'b0;
    bit         recv_calm     = 1'b0;
    bit         hold_request  = 1'b0;
    bit         hold_done     = 1'b0;

    epoch_to_calendar i_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_date_word calendar_of(input logic [32:0] secs);
        t_date_word      d;
        longint unsigned t;
        longint unsigned days;
        int              cyc_day;
        int              years;
        int              leap;
        int              m;
        d = '0;
        if (secs > e2cal_pkg::LAST_SECOND) begin
            d.oor = 1'b1;
            return d;
        end
        t = longint'(secs);
        d.second = 6'(t % 60);
        t = t / 60;
        d.minute = 6'(t % 60);
        t = t / 60;
        d.hour = 5'(t % 24);
        days = t / 24;
        d.wday = 3'((days + e2cal_pkg::EPOCH_WDAY) % 7);
        years = int'(days / e2cal_pkg::DAYS_PER_CYC) * 4;
        cyc_day = int'(days % e2cal_pkg::DAYS_PER_CYC);
        leap = 0;
        if (cyc_day >= e2cal_pkg::YEAR3_START) begin
            years += 3;
            cyc_day -= e2cal_pkg::YEAR3_START;
        end else if (cyc_day >= e2cal_pkg::YEAR2_START) begin
            years += 2;
            cyc_day -= e2cal_pkg::YEAR2_START;
            leap = 1;
        end else if (cyc_day >= e2cal_pkg::YEAR1_START) begin
            years += 1;
            cyc_day -= e2cal_pkg::YEAR1_START;
        end
        m = 0;
        for (int i = 1; i < 12; i++) begin
            if (DAYS_BEFORE_MONTH[leap][i] <= cyc_day) begin
                m = i;
            end
        end
        d.year = 8'(years + e2cal_pkg::EPOCH_YEAR);
        d.yday = 9'(cyc_day);
        d.mon  = 4'(m);
        d.mday = 5'(cyc_day + 1 - DAYS_BEFORE_MONTH[leap][m]);
        return d;
    endfunction

    function automatic logic [39:0] draw_epoch_word();
        logic [39:0]     w;
        longint unsigned day;
        longint unsigned sod;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            // anywhere in the supported span
            do begin
                w = {8'd0, $urandom()};
            end while (w[32:0] > e2cal_pkg::LAST_SECOND);
        end else if (pick < 85) begin
            day = longint'(e2cal_pkg::DAYS_PER_CYC) * $urandom_range(0, 32)
                + CYCLE_EDGES[$urandom_range(0, NUM_EDGES - 1)];
            case ($urandom_range(0, 2))
                0:       sod = 0;
                1:       sod = e2cal_pkg::SEC_PER_DAY - 1;
                default: sod = $urandom_range(0, e2cal_pkg::SEC_PER_DAY - 1);
            endcase
            w = 40'(day * e2cal_pkg::SEC_PER_DAY + sod);
        end else begin
            // past the end of 2099
            do begin
                w = {7'd0, 1'($urandom_range(0, 1)), $urandom()};
            end while (w[32:0] <= e2cal_pkg::LAST_SECOND);
        end
        if ($urandom_range(0, 19) == 0) begin
            w[39:33] = 7'($urandom_range(1, 127));
        end
        return w;
    endfunction

    task automatic offer_word(input logic [39:0] word, input t_date_word want);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        pending_dates.push_back(want);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // stimulus
    initial begin
        t_date_word  want;
        logic [39:0] word;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[k]) begin
            if (directed_rows[k].typed) begin
                want        = '0;
                want.oor    = directed_rows[k].oor;
                want.second = 6'(directed_rows[k].sec);
                want.minute = 6'(directed_rows[k].mnt);
                want.hour   = 5'(directed_rows[k].hr);
                want.wday   = 3'(directed_rows[k].wd);
                want.year   = 8'(directed_rows[k].yr);
                want.yday   = 9'(directed_rows[k].yd);
                want.mon    = 4'(directed_rows[k].mo);
                want.mday   = 5'(directed_rows[k].md);
            end else begin
                want = calendar_of(directed_rows[k].word[32:0]);
            end
            offer_word(directed_rows[k].word, want);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150) begin
                hold_request = 1'b1;
            end
            word = draw_epoch_word();
            offer_word(word, calendar_of(word[32:0]));
        end
        i_s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // output side ready
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                if ($urandom_range(0, 63) == 0) begin
                    recv_calm = !recv_calm;
                end
                gap = recv_calm ? 0 : $urandom_range(0, 18);
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_date_word got;
        t_date_word want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tuser, o_m_tdata};
                if (pending_dates.size() == 0) begin
                    $error("unexpected output word %h", got);
                    mismatches++;
                end else begin
                    want = pending_dates.pop_front();
                    check_field("out_of_range", want.oor, got.oor);
                    check_field("pad", want.pad, got.pad);
                    check_field("second", want.second, got.second);
                    check_field("minute", want.minute, got.minute);
                    check_field("hour", want.hour, got.hour);
                    check_field("weekday", want.wday, got.wday);
                    check_field("years_since_1900", want.year, got.year);
                    check_field("day_of_year", want.yday, got.yday);
                    check_field("month_index", want.mon, got.mon);
                    check_field("day_of_month", want.mday, got.mday);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

endmodule
